### hw/rtl/dbsm_pkg.sv
// Shared types and constants of the draw batch slot manager.
// Depends on nothing; the front end, queue, back end and top level import it.
`default_nettype none

package dbsm_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_RENDER    = 2'd0;
  localparam logic [1:0] CMD_FLUSH_ONE = 2'd1;
  localparam logic [1:0] CMD_FLUSH_ALL = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_FLUSHED  = 2'd0;
  localparam logic [1:0] KIND_ADDED    = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;
  localparam logic [1:0] KIND_DONE     = 2'd3;

  // Configuration register indexes.
  localparam logic [0:0] REG_MAX_VERTS   = 1'b0;
  localparam logic [0:0] REG_MAX_INDICES = 1'b1;

  localparam logic [15:0] NO_SKIN         = 16'hFFFF;
  localparam logic [15:0] MAX_VERTS_RST   = 16'd4096;
  localparam logic [15:0] MAX_INDICES_RST = 16'd8192;

  localparam int QUEUE_DEPTH = 2;

  // Operation after classification in the front end.
  typedef enum logic [1:0] {
    OP_RENDER,
    OP_FLUSH_ONE,
    OP_FLUSH_ALL,
    OP_REJECT
  } op_t;

  // One classified command as it travels through the queue.
  typedef struct packed {
    op_t         op;
    logic [1:0]  fmt;
    logic [15:0] skin;
    logic [15:0] verts;
    logic [15:0] used;
  } item_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_CHECK,
    ST_FLUSH,
    ST_DONE,
    ST_REJECT
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/dbsm_if.sv
// Channel interfaces of the draw batch slot manager: request, result and
// configuration write. Standalone; no package needed.
`default_nettype none

interface dbsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  vertex_format;
  logic [15:0] skin_id;
  logic [15:0] vert_count;
  logic [15:0] index_count;
  logic        has_indices;

  modport source (output valid, cmd, vertex_format, skin_id, vert_count, index_count,
                  has_indices, input ready);
  modport sink (input valid, cmd, vertex_format, skin_id, vert_count, index_count,
                has_indices, output ready);
endinterface

interface dbsm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  out_format;
  logic [2:0]  slot;
  logic [15:0] out_skin;
  logic [15:0] flushed_verts;
  logic [15:0] flushed_indices;
  logic [15:0] base_vertex;
  logic [15:0] index_offset;
  logic [15:0] indices_used;
  logic        last;

  modport source (output valid, kind, out_format, slot, out_skin, flushed_verts,
                  flushed_indices, base_vertex, index_offset, indices_used, last,
                  input ready);
  modport sink (input valid, kind, out_format, slot, out_skin, flushed_verts,
                flushed_indices, base_vertex, index_offset, indices_used, last,
                output ready);
endinterface

interface dbsm_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/dbsm_front.sv
// Front end: takes request beats and classifies them into queue items.
// Depends on dbsm_pkg and dbsm_in_if.
`default_nettype none

module dbsm_front
  import dbsm_pkg::*;
#(
  parameter int FORMATS = 3
) (
  dbsm_in_if.sink    req,
  input  logic       q_full,
  output logic       push,
  output item_t      item
);

  logic fmt_ok;

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;
  assign fmt_ok    = {1'b0, req.vertex_format} < 3'(FORMATS);

  always_comb begin
    item.fmt   = req.vertex_format;
    item.skin  = req.skin_id;
    item.verts = req.vert_count;
    // Without supplied indices the request draws its vertices in order.
    item.used  = req.has_indices ? req.index_count : req.vert_count;
    unique case (req.cmd)
      CMD_RENDER:    item.op = fmt_ok ? OP_RENDER : OP_REJECT;
      CMD_FLUSH_ONE: item.op = fmt_ok ? OP_FLUSH_ONE : OP_REJECT;
      CMD_FLUSH_ALL: item.op = OP_FLUSH_ALL;
      default:       item.op = OP_REJECT;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/dbsm_queue.sv
// Short queue between front and back end of the slot manager.
// Depends on dbsm_pkg for the item type and depth.
`default_nettype none

module dbsm_queue
  import dbsm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = count == CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dbsm_back.sv
// Back end: slot state, configuration registers, the command sequencer and
// the result register. Depends on dbsm_pkg, dbsm_out_if and dbsm_cfg_if.
`default_nettype none

module dbsm_back
  import dbsm_pkg::*;
#(
  parameter int SLOTS   = 8,
  parameter int FORMATS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  item_t       head,
  output logic        pop,
  dbsm_cfg_if.sink    cfg,
  dbsm_out_if.source  res
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FMT_W  = (FORMATS > 1) ? $clog2(FORMATS) : 1;

  // Slot state, one row of SLOTS per vertex format.
  logic [15:0] slot_skin [FORMATS][SLOTS];
  logic [15:0] slot_vc   [FORMATS][SLOTS];
  logic [15:0] slot_ic   [FORMATS][SLOTS];

  logic [15:0] max_verts;
  logic [15:0] max_indices;

  state_t            state;
  state_t            state_next;
  item_t             cur;
  logic [FMT_W-1:0]  cf;
  logic [SLOT_W-1:0] chosen;
  logic [FMT_W-1:0]  fl_fmt;
  logic [FMT_W-1:0]  fl_end;
  logic [SLOT_W-1:0] fl_slot;

  // Scan of the head item's format row.
  logic [FMT_W-1:0]  hf;
  logic              m_found;
  logic [SLOT_W-1:0] m_idx;
  logic              e_found;
  logic [SLOT_W-1:0] e_idx;
  logic [SLOT_W-1:0] f_idx;
  logic [15:0]       f_val;

  // Chosen slot and flush pointer views.
  logic [15:0] c_skin;
  logic [15:0] c_vc;
  logic [15:0] c_ic;
  logic [15:0] ev;
  logic        oversize;
  logic        overflow;
  logic [15:0] p_skin;
  logic [15:0] p_vc;
  logic [15:0] p_ic;
  logic        fl_wrap;
  logic        fl_fin;
  logic        fl_step;

  // Result register.
  logic        out_valid;
  logic        o_free;
  logic        out_load;
  logic [1:0]  o_kind;
  logic [1:0]  o_fmt;
  logic [2:0]  o_slot;
  logic [15:0] o_skin;
  logic [15:0] o_fv;
  logic [15:0] o_fi;
  logic [15:0] o_bv;
  logic [15:0] o_io;
  logic [15:0] o_iu;
  logic        o_last;

  // Single slot write port.
  logic              wr_skin_en;
  logic              wr_cnt_en;
  logic [FMT_W-1:0]  wr_f;
  logic [SLOT_W-1:0] wr_s;
  logic [15:0]       wr_skin;
  logic [15:0]       wr_vc;
  logic [15:0]       wr_ic;

  assign cfg.ready = 1'b1;
  assign o_free    = !out_valid || res.ready;
  assign hf        = head.fmt[FMT_W-1:0];

  // First tag match, last empty slot and first fullest slot of the row.
  always_comb begin
    m_found = 1'b0;
    m_idx   = '0;
    e_found = 1'b0;
    e_idx   = '0;
    f_idx   = '0;
    f_val   = slot_vc[hf][0];
    for (int s = 0; s < SLOTS; s++) begin
      if (!m_found && slot_skin[hf][s] == head.skin) begin
        m_found = 1'b1;
        m_idx   = SLOT_W'(s);
      end
      if (slot_vc[hf][s] == '0) begin
        e_found = 1'b1;
        e_idx   = SLOT_W'(s);
      end
      if (slot_vc[hf][s] > f_val) begin
        f_val = slot_vc[hf][s];
        f_idx = SLOT_W'(s);
      end
    end
  end

  assign c_skin   = slot_skin[cf][chosen];
  assign c_vc     = slot_vc[cf][chosen];
  assign c_ic     = slot_ic[cf][chosen];
  assign ev       = (c_vc == '0) ? '0 : c_ic;
  assign oversize = (cur.verts > max_verts) || (cur.used > max_indices);
  assign overflow = ({1'b0, c_vc} + {1'b0, cur.verts} > {1'b0, max_verts}) ||
                    ({1'b0, ev} + {1'b0, cur.used} > {1'b0, max_indices});

  assign p_skin  = slot_skin[fl_fmt][fl_slot];
  assign p_vc    = slot_vc[fl_fmt][fl_slot];
  assign p_ic    = slot_ic[fl_fmt][fl_slot];
  assign fl_wrap = fl_slot == SLOT_W'(SLOTS - 1);
  assign fl_fin  = fl_wrap && (fl_fmt == fl_end);
  assign fl_step = (p_vc == '0) || o_free;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          unique case (head.op) inside
            OP_RENDER:                  state_next = (m_found || e_found) ? ST_CHECK : ST_EVICT;
            OP_FLUSH_ONE, OP_FLUSH_ALL: state_next = ST_FLUSH;
            default:                    state_next = ST_REJECT;
          endcase
        end
      end
      ST_EVICT: begin
        if (o_free) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        // An overflowing slot is spilled first and then checked again.
        if (o_free) state_next = (!oversize && overflow) ? ST_CHECK : ST_IDLE;
      end
      ST_FLUSH: begin
        if (fl_step && fl_fin) state_next = ST_DONE;
      end
      ST_DONE, ST_REJECT: begin
        if (o_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: queue pop, result load and slot write.
  always_comb begin
    pop        = 1'b0;
    out_load   = 1'b0;
    o_kind     = KIND_REJECTED;
    o_fmt      = '0;
    o_slot     = '0;
    o_skin     = NO_SKIN;
    o_fv       = '0;
    o_fi       = '0;
    o_bv       = '0;
    o_io       = '0;
    o_iu       = '0;
    o_last     = 1'b0;
    wr_skin_en = 1'b0;
    wr_cnt_en  = 1'b0;
    wr_f       = cf;
    wr_s       = chosen;
    wr_skin    = cur.skin;
    wr_vc      = '0;
    wr_ic      = '0;
    unique case (state)
      ST_IDLE: begin
        pop = head_valid;
        if (head_valid && head.op == OP_RENDER && !m_found && e_found) begin
          wr_skin_en = 1'b1;
          wr_f       = hf;
          wr_s       = e_idx;
          wr_skin    = head.skin;
        end
      end
      ST_EVICT: begin
        if (o_free) begin
          out_load   = 1'b1;
          o_kind     = KIND_FLUSHED;
          o_fmt      = 2'(cf);
          o_slot     = 3'(chosen);
          o_skin     = c_skin;
          o_fv       = c_vc;
          o_fi       = c_ic;
          wr_skin_en = 1'b1;
          wr_cnt_en  = 1'b1;
        end
      end
      ST_CHECK: begin
        if (o_free) begin
          out_load = 1'b1;
          o_fmt    = 2'(cf);
          o_slot   = 3'(chosen);
          if (oversize) begin
            o_kind = KIND_REJECTED;
            o_skin = cur.skin;
            o_last = 1'b1;
          end else if (overflow) begin
            o_kind    = KIND_FLUSHED;
            o_skin    = c_skin;
            o_fv      = c_vc;
            o_fi      = c_ic;
            wr_cnt_en = 1'b1;
          end else begin
            o_kind    = KIND_ADDED;
            o_skin    = cur.skin;
            o_bv      = c_vc;
            o_io      = ev;
            o_iu      = cur.used;
            o_last    = 1'b1;
            wr_cnt_en = 1'b1;
            wr_vc     = c_vc + cur.verts;
            wr_ic     = ev + cur.used;
          end
        end
      end
      ST_FLUSH: begin
        wr_f = fl_fmt;
        wr_s = fl_slot;
        if (p_vc != '0 && o_free) begin
          out_load  = 1'b1;
          o_kind    = KIND_FLUSHED;
          o_fmt     = 2'(fl_fmt);
          o_slot    = 3'(fl_slot);
          o_skin    = p_skin;
          o_fv      = p_vc;
          o_fi      = p_ic;
          wr_cnt_en = 1'b1;
        end
      end
      ST_DONE: begin
        if (o_free) begin
          out_load = 1'b1;
          o_kind   = KIND_DONE;
          o_fmt    = (cur.op == OP_FLUSH_ONE) ? cur.fmt : 2'd0;
          o_last   = 1'b1;
        end
      end
      ST_REJECT: begin
        if (o_free) begin
          out_load = 1'b1;
          o_last   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      max_verts   <= MAX_VERTS_RST;
      max_indices <= MAX_INDICES_RST;
      for (int f = 0; f < FORMATS; f++) begin
        for (int s = 0; s < SLOTS; s++) begin
          slot_skin[f][s] <= NO_SKIN;
          slot_vc[f][s]   <= '0;
          slot_ic[f][s]   <= '0;
        end
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_MAX_VERTS:   max_verts   <= cfg.data;
          REG_MAX_INDICES: max_indices <= cfg.data;
        endcase
      end
      if (wr_skin_en) begin
        slot_skin[wr_f][wr_s] <= wr_skin;
      end
      if (wr_cnt_en) begin
        slot_vc[wr_f][wr_s] <= wr_vc;
        slot_ic[wr_f][wr_s] <= wr_ic;
      end
    end
  end

  // Item context and flush pointer.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && head_valid) begin
      cur     <= head;
      cf      <= hf;
      chosen  <= m_found ? m_idx : (e_found ? e_idx : f_idx);
      fl_slot <= '0;
      fl_fmt  <= (head.op == OP_FLUSH_ALL) ? '0 : hf;
      fl_end  <= (head.op == OP_FLUSH_ALL) ? FMT_W'(FORMATS - 1) : hf;
    end else if (state == ST_FLUSH && fl_step && !fl_fin) begin
      if (fl_wrap) begin
        fl_slot <= '0;
        fl_fmt  <= fl_fmt + 1'b1;
      end else begin
        fl_slot <= fl_slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.kind            <= o_kind;
      res.out_format      <= o_fmt;
      res.slot            <= o_slot;
      res.out_skin        <= o_skin;
      res.flushed_verts   <= o_fv;
      res.flushed_indices <= o_fi;
      res.base_vertex     <= o_bv;
      res.index_offset    <= o_io;
      res.indices_used    <= o_iu;
      res.last            <= o_last;
    end
  end

  assign res.valid = out_valid;

  // Only a slot that holds vertices is ever evicted.
  a_evict_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVICT |-> c_vc != '0)
    else $error("evicting an empty slot");

  // After a spill the slot is empty, so the second check cannot spill again.
  a_spill_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK && o_free && !oversize && overflow |=> state == ST_CHECK && c_vc == '0)
    else $error("spilled slot not empty on recheck");

  // The final beat of a command returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    out_load && o_last |=> state == ST_IDLE)
    else $error("sequencer busy after final beat");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.ready |-> !out_load)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

### hw/rtl/draw_batch_slot_manager.sv
// Top level of the draw batch slot manager: front end, queue and back end.
// Depends on dbsm_pkg, dbsm_if, dbsm_front, dbsm_queue and dbsm_back.
//
// Usage. Three valid/ready channels. req carries commands: render request,
// flush one vertex format, or flush all formats. res returns result beats;
// every command yields one or more beats and the final beat has last set.
// cfg writes the per-slot capacity registers (index 0 vertex capacity,
// index 1 index capacity); it is always ready and is meant to be written
// only while no command is in flight.
// Sequencing. A request beat enters a two-entry queue in the cycle it is
// accepted; the idle sequencer picks it up from the queue head, scans the
// SLOTS slots of its format in parallel in that cycle, and then delivers the
// added or rejected beat. Each eviction or spill first emits a flushed beat.
// A flush command walks its slots one per cycle, a slot that holds vertices
// waiting while res is stalled, and then emits the done beat. The sequencer
// finishes one command before it takes the next; it has one slot write port.
// Reset. rst (synchronous) empties the queue, drops any pending result,
// loads capacities 4096 and 8192, and untags and empties every slot.
// Stalls. Results sit in an output register; while res is stalled the
// sequencer holds its next beat; req keeps accepting until the queue is full.
`default_nettype none

module draw_batch_slot_manager
  import dbsm_pkg::*;
#(
  parameter int SLOTS   = 8,
  parameter int FORMATS = 3
) (
  input  logic       clk,
  input  logic       rst,
  dbsm_in_if.sink    req,
  dbsm_cfg_if.sink   cfg,
  dbsm_out_if.source res
);

  logic  q_full;
  logic  push;
  item_t push_item;
  logic  pop;
  logic  head_valid;
  item_t head;

  // Classification of incoming command beats.
  dbsm_front #(
    .FORMATS (FORMATS)
  ) u_front (
    .req    (req),
    .q_full (q_full),
    .push   (push),
    .item   (push_item)
  );

  // Decoupling queue so the front keeps taking beats while the back works.
  dbsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Slot state, sequencing and the result register.
  dbsm_back #(
    .SLOTS   (SLOTS),
    .FORMATS (FORMATS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .cfg        (cfg),
    .res        (res)
  );

endmodule

`default_nettype wire
